[sv/hdlc_like_frame_receiver_unit_defines.svh]
// assertion macros for the frame receiver
`ifndef HDLC_LIKE_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define HDLC_LIKE_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define HDLC_RX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define HDLC_RX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HDLC_RX_ASSERT(lbl, clk, rst_n, prop, msg)
`define HDLC_RX_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/hdlcrx_pkg.sv]
// types and codes shared by the frame receiver files, and the rtl crc step
`default_nettype none

package hdlcrx_pkg;

  localparam logic [7:0]  FLAG_BYTE     = 8'h7e;
  localparam logic [7:0]  ESC_BYTE      = 8'h7d;
  localparam logic [7:0]  ESC_XOR       = 8'h20;
  localparam logic [15:0] CRC_POLY      = 16'h8408;
  localparam int unsigned TRAILER_BYTES = 2;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRC_SEED     = 2'd0,
    CFG_GOOD_RESIDUE = 2'd1
  } cfg_reg_e;

  localparam logic [15:0] CRC_SEED_RST     = 16'hffff;
  localparam logic [15:0] GOOD_RESIDUE_RST = 16'hf0b8;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_GOOD    = 3'd1,
    ST_CRC_ERR = 3'd2,
    ST_SHORT   = 3'd3,
    ST_ABORT   = 3'd4
  } status_e;

  typedef struct packed {
    logic        store_valid;
    logic [7:0]  store_byte;
    logic [5:0]  store_index;
    logic [2:0]  frame_status;
    logic [5:0]  payload_length;
    logic [15:0] crc_error_total;
  } res_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/hdlcrx_if.sv]
// handshake interfaces for the byte, result and configuration channels
`default_nettype none

interface hdlcrx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hdlcrx_res_if;
  logic        valid;
  logic        ready;
  logic        store_valid;
  logic [7:0]  store_byte;
  logic [5:0]  store_index;
  logic [2:0]  frame_status;
  logic [5:0]  payload_length;
  logic [15:0] crc_error_total;

  modport source (output valid, output store_valid, output store_byte, output store_index,
                  output frame_status, output payload_length, output crc_error_total,
                  input ready);
  modport sink   (input valid, input store_valid, input store_byte, input store_index,
                  input frame_status, input payload_length, input crc_error_total,
                  output ready);
endinterface

interface hdlcrx_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hdlcrx_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/hdlc_like_frame_receiver_unit.sv]
// top level of the async hdlc style frame receiver with crc-16 check
`default_nettype none
`include "hdlc_like_frame_receiver_unit_defines.svh"

// The receiver takes one raw line byte per word on rx_i and gives exactly one
// result word on res_o for each. 0x7e delimits frames, 0x7d escapes the next
// byte (xor 0x20); escape-escape or escape-flag aborts an open frame. Frame
// bytes, crc trailer included, come out with their index while the frame has
// fewer than BUFFER_BYTES stored; later bytes still enter the crc. A closing
// flag reports good (with payload length), crc error or too short. Timing: a
// byte is accepted while the skid word is empty and its result is registered,
// so throughput is one byte per cycle unless res_o stalls; the limit is the
// combinational byte crc update feeding the running crc register. A two-word
// output buffer lets the input keep flowing for one more word while a result
// waits. Nothing needs clearing after reset. Write cfg_i (index 0 crc seed, 1
// good residue) only while the block is idle; cfg_i is always ready.
module hdlc_like_frame_receiver_unit #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hdlcrx_cfg_if.sink           cfg_i,
  hdlcrx_byte_if.sink          rx_i,
  hdlcrx_res_if.source         res_o
);

  // count must hold BUFFER_BYTES itself
  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
  // widened count so a six bit view always exists
  localparam int unsigned EXT_W = (CNT_W > 6) ? CNT_W : 6;

  // configuration registers
  logic [15:0] crc_seed_q;
  logic [15:0] good_residue_q;

  // frame state
  logic [7:0]       prev_byte_q;
  logic [CNT_W-1:0] frame_count_q, frame_count_d;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      crc_err_q, crc_err_d;

  // output buffer: out is presented, skid holds the overflow word
  hdlcrx_pkg::res_t res_d;
  hdlcrx_pkg::res_t out_q;
  hdlcrx_pkg::res_t skid_q;
  logic             out_valid_q;
  logic             skid_valid_q;

  logic rx_acc;
  logic res_take;

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = !skid_valid_q;
  assign rx_acc      = rx_i.valid && rx_i.ready;
  assign res_take    = out_valid_q && res_o.ready;

  // configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_seed_q     <= hdlcrx_pkg::CRC_SEED_RST;
      good_residue_q <= hdlcrx_pkg::GOOD_RESIDUE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        hdlcrx_pkg::CFG_CRC_SEED:     crc_seed_q     <= cfg_i.data;
        hdlcrx_pkg::CFG_GOOD_RESIDUE: good_residue_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // per byte deframing decision
  logic [7:0]       rx_c;
  logic [7:0]       data_c;
  logic             open_c;
  logic [15:0]      crc_base;
  logic [EXT_W-1:0] cnt_ext;
  logic [EXT_W-1:0] plen_ext;

  always_comb begin
    rx_c     = rx_i.rx_byte;
    open_c   = (frame_count_q != '0);
    cnt_ext  = EXT_W'(frame_count_q);
    plen_ext = cnt_ext - EXT_W'(hdlcrx_pkg::TRAILER_BYTES);
    // unescape when the previous raw byte was an escape
    data_c   = (prev_byte_q == hdlcrx_pkg::ESC_BYTE) ? (rx_c ^ hdlcrx_pkg::ESC_XOR) : rx_c;
    // first byte of a frame starts from the seed
    crc_base = open_c ? crc_q : crc_seed_q;

    frame_count_d = frame_count_q;
    crc_d         = crc_q;
    crc_err_d     = crc_err_q;

    res_d                = '0;
    res_d.frame_status   = hdlcrx_pkg::ST_NONE;

    if (rx_c == hdlcrx_pkg::ESC_BYTE) begin
      // escape escape kills an open frame
      if (prev_byte_q == hdlcrx_pkg::ESC_BYTE && open_c) begin
        res_d.frame_status = hdlcrx_pkg::ST_ABORT;
        frame_count_d      = '0;
      end
    end else if (rx_c == hdlcrx_pkg::FLAG_BYTE) begin
      if (open_c) begin
        if (prev_byte_q == hdlcrx_pkg::ESC_BYTE) begin
          res_d.frame_status = hdlcrx_pkg::ST_ABORT;
        end else if (frame_count_q > CNT_W'(hdlcrx_pkg::TRAILER_BYTES)) begin
          if (crc_q == good_residue_q) begin
            res_d.frame_status   = hdlcrx_pkg::ST_GOOD;
            res_d.payload_length = plen_ext[5:0];
          end else begin
            res_d.frame_status = hdlcrx_pkg::ST_CRC_ERR;
            crc_err_d          = crc_err_q + 16'd1;
          end
        end else begin
          res_d.frame_status = hdlcrx_pkg::ST_SHORT;
        end
      end
      frame_count_d = '0;
    end else if (open_c || prev_byte_q == hdlcrx_pkg::FLAG_BYTE) begin
      // frame byte: store while there is room, always fold into the crc
      if (frame_count_q < CNT_W'(BUFFER_BYTES)) begin
        res_d.store_valid = 1'b1;
        res_d.store_byte  = data_c;
        res_d.store_index = cnt_ext[5:0];
        frame_count_d     = frame_count_q + CNT_W'(1);
      end
      crc_d = hdlcrx_pkg::crc16_byte(crc_base, data_c);
    end

    res_d.crc_error_total = crc_err_d;
  end

  // frame state advances on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_byte_q   <= '0;
      frame_count_q <= '0;
      crc_q         <= '0;
      crc_err_q     <= '0;
    end else if (rx_acc) begin
      prev_byte_q   <= rx_i.rx_byte;
      frame_count_q <= frame_count_d;
      crc_q         <= crc_d;
      crc_err_q     <= crc_err_d;
    end
  end

  // output buffer valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || res_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= rx_acc;
      end else begin
        out_valid_q  <= rx_acc;
      end
    end else if (rx_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output buffer payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || res_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (rx_acc) begin
          skid_q <= res_d;
        end
      end else if (rx_acc) begin
        out_q <= res_d;
      end
    end else if (rx_acc) begin
      skid_q <= res_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.store_valid     = out_q.store_valid;
  assign res_o.store_byte      = out_q.store_byte;
  assign res_o.store_index     = out_q.store_index;
  assign res_o.frame_status    = out_q.frame_status;
  assign res_o.payload_length  = out_q.payload_length;
  assign res_o.crc_error_total = out_q.crc_error_total;

  // the skid word never exists without a presented word
  `HDLC_RX_ASSERT_ALWAYS(a_skid_needs_out, clk_i, skid_valid_q |-> out_valid_q, "skid valid while output empty")
  // stored count stays within the buffer
  `HDLC_RX_ASSERT(a_count_bound, clk_i, rst_ni, frame_count_q <= CNT_W'(BUFFER_BYTES), "frame count beyond buffer")
  // error counter moves only with a crc error word
  `HDLC_RX_ASSERT(a_err_only_on_crc, clk_i, rst_ni, (!rx_acc || res_d.frame_status != hdlcrx_pkg::ST_CRC_ERR) |=> $stable(crc_err_q), "crc error count changed without a crc error")
  // a stored byte never comes with a frame verdict
  `HDLC_RX_ASSERT(a_store_no_status, clk_i, rst_ni, (out_valid_q && out_q.store_valid) |-> (out_q.frame_status == hdlcrx_pkg::ST_NONE), "stored byte carries a frame status")

endmodule

`default_nettype wire

[test/hdlc_like_frame_receiver_unit_tb.sv]
// self-checking testbench for the hdlc style frame receiver: framed and noisy byte traffic
`timescale 1ns / 1ps

module hdlc_like_frame_receiver_unit_tb;

  localparam int unsigned RX_BUF_BYTES = 64;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_LIMIT  = 5000;

  // shapes of generated frames
  typedef enum int unsigned {
    FRAME_INTACT,
    FRAME_CORRUPT,
    FRAME_ABORT_ESC,
    FRAME_ABORT_FLAG
  } frame_kind_e;

  // predicts one result word per line byte and checks the block's results against it
  class deframer_scoreboard;
    logic [15:0]      crc_seed     = hdlcrx_pkg::CRC_SEED_RST;
    logic [15:0]      good_residue = hdlcrx_pkg::GOOD_RESIDUE_RST;
    logic [7:0]       last_raw     = 8'h00;
    int unsigned      stored_count = 0;
    logic [15:0]      crc_acc      = 16'h0000;
    logic [15:0]      crc_errors   = 16'h0000;
    hdlcrx_pkg::res_t pending_results[$];
    int unsigned      results_seen = 0;
    int unsigned      fail_count   = 0;

    // reflected crc-16, poly 0x8408, lsb first
    static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] d);
      logic [15:0] r;
      r = crc ^ {8'h00, d};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ hdlcrx_pkg::CRC_POLY) : (r >> 1);
      end
      return r;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
    endtask

    task note_byte(logic [7:0] raw);
      hdlcrx_pkg::res_t want;
      logic [7:0]       prior;
      logic [7:0]       data;
      want  = '0;
      prior = last_raw;
      data  = raw;
      last_raw = raw;
      if (raw == hdlcrx_pkg::ESC_BYTE) begin
        // escape escape kills an open frame only
        if (prior == hdlcrx_pkg::ESC_BYTE && stored_count != 0) begin
          want.frame_status = hdlcrx_pkg::ST_ABORT;
          stored_count = 0;
        end
      end else if (raw == hdlcrx_pkg::FLAG_BYTE) begin
        if (stored_count != 0) begin
          if (prior == hdlcrx_pkg::ESC_BYTE) begin
            want.frame_status = hdlcrx_pkg::ST_ABORT;
          end else if (stored_count > hdlcrx_pkg::TRAILER_BYTES) begin
            if (crc_acc == good_residue) begin
              want.frame_status   = hdlcrx_pkg::ST_GOOD;
              want.payload_length = 6'(stored_count - hdlcrx_pkg::TRAILER_BYTES);
            end else begin
              want.frame_status = hdlcrx_pkg::ST_CRC_ERR;
              crc_errors++;
            end
          end else begin
            want.frame_status = hdlcrx_pkg::ST_SHORT;
          end
        end
        stored_count = 0;
      end else if (stored_count != 0 || prior == hdlcrx_pkg::FLAG_BYTE) begin
        // a byte right after flag-escape never gets here: dropped
        if (stored_count == 0) crc_acc = crc_seed;
        if (prior == hdlcrx_pkg::ESC_BYTE) data = raw ^ hdlcrx_pkg::ESC_XOR;
        if (stored_count < RX_BUF_BYTES) begin
          want.store_valid = 1'b1;
          want.store_byte  = data;
          want.store_index = 6'(stored_count);
          stored_count++;
        end
        // past the buffer the crc still runs
        crc_acc = crc_update(crc_acc, data);
      end
      want.crc_error_total = crc_errors;
      pending_results.push_back(want);
    endtask

    task check_result(hdlcrx_pkg::res_t got);
      hdlcrx_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("word %0d came with nothing expected", results_seen));
        results_seen++;
        return;
      end
      want = pending_results.pop_front();
      if (got.store_valid !== want.store_valid)
        report($sformatf("word %0d store_valid %b want %b", results_seen,
                         got.store_valid, want.store_valid));
      if (got.store_byte !== want.store_byte)
        report($sformatf("word %0d store_byte %h want %h", results_seen,
                         got.store_byte, want.store_byte));
      if (got.store_index !== want.store_index)
        report($sformatf("word %0d store_index %0d want %0d", results_seen,
                         got.store_index, want.store_index));
      if (got.frame_status !== want.frame_status)
        report($sformatf("word %0d frame_status %0d want %0d", results_seen,
                         got.frame_status, want.frame_status));
      if (got.payload_length !== want.payload_length)
        report($sformatf("word %0d payload_length %0d want %0d", results_seen,
                         got.payload_length, want.payload_length));
      if (got.crc_error_total !== want.crc_error_total)
        report($sformatf("word %0d crc_error_total %h want %h", results_seen,
                         got.crc_error_total, want.crc_error_total));
      results_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hdlcrx_byte_if rx_if();
  hdlcrx_res_if  res_if();
  hdlcrx_cfg_if  cfg_if();

  deframer_scoreboard sb = new();

  // sender and receiver pacing
  bit          tx_calm    = 1'b0;
  bit          rx_calm    = 1'b0;
  bit          hold_req   = 1'b0;
  logic [7:0]  last_sent  = 8'h00;
  int unsigned bytes_sent = 0;

  hdlc_like_frame_receiver_unit #(
    .BUFFER_BYTES(RX_BUF_BYTES)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both handshakes sampled at the same edge: the accepted byte is predicted
  // before any result of that edge is checked
  always @(posedge clk) begin : handshake_monitor
    hdlcrx_pkg::res_t seen;
    if (rst_n) begin
      if (rx_if.valid && rx_if.ready) sb.note_byte(rx_if.rx_byte);
      if (res_if.valid && res_if.ready) begin
        seen = {res_if.store_valid, res_if.store_byte, res_if.store_index,
                res_if.frame_status, res_if.payload_length, res_if.crc_error_total};
        sb.check_result(seen);
      end
    end
  end

  // result side: random stall per word, calm stretches, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    res_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        // long hold so the output buffer fills and the input backs up
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 24) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
    end
  end

  // one line byte; valid stays up when the next word follows with no gap
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    last_sent = b;
    bytes_sent++;
  endtask

  // escape flag and escape always, other bytes now and then
  task automatic put_escaped(ref logic [7:0] line_q[$], input logic [7:0] b);
    bit spare;
    spare = (b != (hdlcrx_pkg::FLAG_BYTE ^ hdlcrx_pkg::ESC_XOR) &&
             b != (hdlcrx_pkg::ESC_BYTE ^ hdlcrx_pkg::ESC_XOR) &&
             $urandom_range(0, 9) == 0);
    if (b == hdlcrx_pkg::FLAG_BYTE || b == hdlcrx_pkg::ESC_BYTE || spare) begin
      line_q.push_back(hdlcrx_pkg::ESC_BYTE);
      line_q.push_back(b ^ hdlcrx_pkg::ESC_XOR);
    end else begin
      line_q.push_back(b);
    end
  endtask

  // builds a frame whose trailer is the crc over the current seed, inverted unless the residue is zero
  task automatic send_frame(frame_kind_e kind, int unsigned n_payload);
    logic [7:0]  body[$];
    logic [7:0]  line_q[$];
    logic [15:0] crc;
    logic [15:0] trailer;
    int unsigned cut;
    crc = sb.crc_seed;
    for (int i = 0; i < n_payload; i++) begin
      body.push_back(8'($urandom_range(0, 255)));
      crc = deframer_scoreboard::crc_update(crc, body[i]);
    end
    // plain crc leaves residue zero, inverted crc leaves 0xf0b8, whatever the seed
    trailer = (sb.good_residue == 16'h0000) ? crc : ~crc;
    body.push_back(trailer[7:0]);
    body.push_back(trailer[15:8]);
    if (kind == FRAME_CORRUPT) begin
      cut = $urandom_range(0, body.size() - 1);
      body[cut] = body[cut] ^ 8'($urandom_range(1, 255));
    end
    // a closing flag may double as the next opening flag
    if (last_sent != hdlcrx_pkg::FLAG_BYTE || $urandom_range(0, 1) == 1)
      line_q.push_back(hdlcrx_pkg::FLAG_BYTE);
    cut = (kind == FRAME_ABORT_ESC || kind == FRAME_ABORT_FLAG) ?
          $urandom_range(1, body.size()) : body.size();
    for (int i = 0; i < cut; i++) put_escaped(line_q, body[i]);
    case (kind)
      FRAME_ABORT_ESC: begin
        line_q.push_back(hdlcrx_pkg::ESC_BYTE);
        line_q.push_back(hdlcrx_pkg::ESC_BYTE);
      end
      FRAME_ABORT_FLAG: begin
        line_q.push_back(hdlcrx_pkg::ESC_BYTE);
        line_q.push_back(hdlcrx_pkg::FLAG_BYTE);
      end
      default: line_q.push_back(hdlcrx_pkg::FLAG_BYTE);
    endcase
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  // line noise, heavy on flag and escape
  task automatic send_noise(int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(0, 4))
        0:       b = hdlcrx_pkg::FLAG_BYTE;
        1:       b = hdlcrx_pkg::ESC_BYTE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
  endtask

  // mostly well formed frames, some broken ones and noise
  task automatic run_traffic(int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 9);
      // a few long frames run past the buffer
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 16);
      if (pick < 6) send_frame(FRAME_INTACT, len);
      else if (pick == 6) send_frame(FRAME_CORRUPT, len);
      else if (pick == 7) send_frame(FRAME_ABORT_ESC, len);
      else if (pick == 8) send_frame(FRAME_ABORT_FLAG, len);
      else send_noise($urandom_range(1, 8));
    end
  endtask

  // sender pauses until every expected word is back or the drain limit runs out
  task automatic settle();
    int unsigned waited;
    rx_if.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d result words never came", sb.pending_results.size()));
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(hdlcrx_pkg::cfg_reg_e idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      hdlcrx_pkg::CFG_CRC_SEED:     sb.crc_seed     = val;
      hdlcrx_pkg::CFG_GOOD_RESIDUE: sb.good_residue = val;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] directed_bytes[$];
    // stray bytes, lone flag, escaped first byte, short frame, both aborts,
    // escapes with no frame open, then a frame that fails its crc
    directed_bytes = '{
      8'h00, 8'hff, hdlcrx_pkg::FLAG_BYTE, hdlcrx_pkg::FLAG_BYTE, hdlcrx_pkg::ESC_BYTE,
      8'h41, 8'h42,
      hdlcrx_pkg::FLAG_BYTE, 8'h11, 8'h22, hdlcrx_pkg::FLAG_BYTE,
      8'h33, hdlcrx_pkg::ESC_BYTE, hdlcrx_pkg::ESC_BYTE, hdlcrx_pkg::ESC_BYTE,
      hdlcrx_pkg::ESC_BYTE, hdlcrx_pkg::FLAG_BYTE,
      8'h44, hdlcrx_pkg::ESC_BYTE, hdlcrx_pkg::FLAG_BYTE,
      8'h00, 8'hff, 8'h01, 8'h02, hdlcrx_pkg::FLAG_BYTE
    };
    rst_n         <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= hdlcrx_pkg::CFG_CRC_SEED;
    cfg_if.data   <= 16'h0000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: directed words, one intact frame, then traffic
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    send_frame(FRAME_INTACT, 3);
    run_traffic(300);
    settle();

    // zero seed, zero residue: plain trailer
    write_reg(hdlcrx_pkg::CFG_CRC_SEED, 16'h0000);
    write_reg(hdlcrx_pkg::CFG_GOOD_RESIDUE, 16'h0000);
    run_traffic(200);
    settle();

    // all-ones both: almost every frame is a crc error
    write_reg(hdlcrx_pkg::CFG_CRC_SEED, 16'hffff);
    write_reg(hdlcrx_pkg::CFG_GOOD_RESIDUE, 16'hffff);
    run_traffic(100);
    settle();

    // random seed, standard residue, long hold on the result side
    write_reg(hdlcrx_pkg::CFG_CRC_SEED, 16'($urandom_range(0, 65535)));
    write_reg(hdlcrx_pkg::CFG_GOOD_RESIDUE, hdlcrx_pkg::GOOD_RESIDUE_RST);
    hold_req = 1'b1;
    tx_calm  = 1'b1;
    send_noise(12);
    run_traffic(200);
    settle();

    write_reg(hdlcrx_pkg::CFG_CRC_SEED, 16'($urandom_range(0, 65535)));
    write_reg(hdlcrx_pkg::CFG_GOOD_RESIDUE, 16'h0000);
    run_traffic(200);
    settle();

    if (sb.fail_count == 0) begin
      $display("hdlc_like_frame_receiver_unit_tb passed");
    end else begin
      $display("hdlc_like_frame_receiver_unit_tb failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin : run_limit
    #(3_000_000);
    $display("timeout: handshake stuck");
    $display("hdlc_like_frame_receiver_unit_tb failed");
    $finish;
  end

endmodule
